>>> hdl/spte_pkg.sv
// spte_pkg: types, codes and the microcode program of the sparse polynomial store
// used by sparse_polynomial_term_store_eval; depends on nothing
`default_nettype none

package spte_pkg;

    localparam int COEF_W = 32;
    localparam int EXPO_W = 6;
    localparam int STEP_W = 5;

    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic [EXPO_W-1:0] expo;
    } t_term;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_EVAL  = 2'd2
    } t_opcode;

    typedef enum logic [4:0] {
        A_NOP,
        A_LATCH,
        A_CLEAR,
        A_INC,
        A_DEC,
        A_MERGE,
        A_WR_TERM,
        A_WR_DOWN,
        A_WR_UP,
        A_WR_NEW,
        A_DEC_CNT,
        A_SET_POS,
        A_SET_FULL,
        A_POW_INIT,
        A_POW_STEP,
        A_TERM_MUL,
        A_ACCUM,
        A_EMIT
    } t_act;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOSTART,
        C_OP_ADD,
        C_OP_EVAL,
        C_OP_NCLR,
        C_IDX_EQ_CNT,
        C_EXP_EQ,
        C_EXP_LT,
        C_TERM_NZ,
        C_IDX1_GE_CNT,
        C_CNT_FULL,
        C_IDX_EQ_POS,
        C_E_GT1
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_step target;
    } t_uword;

    localparam t_step S_IDLE      = 5'd0;
    localparam t_step S_DSP_ADD   = 5'd1;
    localparam t_step S_DSP_EVAL  = 5'd2;
    localparam t_step S_DSP_NONE  = 5'd3;
    localparam t_step S_CLEAR     = 5'd4;
    localparam t_step S_SRCH      = 5'd5;
    localparam t_step S_SRCH_EQ   = 5'd6;
    localparam t_step S_SRCH_LT   = 5'd7;
    localparam t_step S_SRCH_NXT  = 5'd8;
    localparam t_step S_MERGE     = 5'd9;
    localparam t_step S_MERGE_WR  = 5'd10;
    localparam t_step S_DEL       = 5'd11;
    localparam t_step S_DEL_INC   = 5'd12;
    localparam t_step S_DEL_RD    = 5'd13;
    localparam t_step S_DEL_WR    = 5'd14;
    localparam t_step S_DEL_END   = 5'd15;
    localparam t_step S_INS       = 5'd16;
    localparam t_step S_SHIFT     = 5'd17;
    localparam t_step S_SHIFT_DEC = 5'd18;
    localparam t_step S_SHIFT_RD  = 5'd19;
    localparam t_step S_SHIFT_WR  = 5'd20;
    localparam t_step S_INS_WR    = 5'd21;
    localparam t_step S_FULL      = 5'd22;
    localparam t_step S_EVAL      = 5'd23;
    localparam t_step S_EVAL_LD   = 5'd24;
    localparam t_step S_POW       = 5'd25;
    localparam t_step S_TERM_MUL  = 5'd26;
    localparam t_step S_ACCUM     = 5'd27;
    localparam t_step S_EMIT      = 5'd28;

    function automatic t_uword uop(input t_act a, input t_cond c, input t_step t);
        t_uword w;
        w.act    = a;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    // control store: on a true condition go to target, else to the next step
    function automatic t_uword uc_rom(input t_step pc);
        t_uword w;
        case (pc)
            S_IDLE:      w = uop(A_LATCH,    C_NOSTART,     S_IDLE);
            S_DSP_ADD:   w = uop(A_NOP,      C_OP_ADD,      S_SRCH);
            S_DSP_EVAL:  w = uop(A_NOP,      C_OP_EVAL,     S_EVAL);
            S_DSP_NONE:  w = uop(A_NOP,      C_OP_NCLR,     S_EMIT);
            S_CLEAR:     w = uop(A_CLEAR,    C_ALWAYS,      S_EMIT);
            S_SRCH:      w = uop(A_NOP,      C_IDX_EQ_CNT,  S_INS);
            S_SRCH_EQ:   w = uop(A_NOP,      C_EXP_EQ,      S_MERGE);
            S_SRCH_LT:   w = uop(A_NOP,      C_EXP_LT,      S_INS);
            S_SRCH_NXT:  w = uop(A_INC,      C_ALWAYS,      S_SRCH);
            S_MERGE:     w = uop(A_MERGE,    C_NEVER,       S_IDLE);
            S_MERGE_WR:  w = uop(A_WR_TERM,  C_TERM_NZ,     S_EMIT);
            S_DEL:       w = uop(A_NOP,      C_IDX1_GE_CNT, S_DEL_END);
            S_DEL_INC:   w = uop(A_INC,      C_NEVER,       S_IDLE);
            S_DEL_RD:    w = uop(A_NOP,      C_NEVER,       S_IDLE);
            S_DEL_WR:    w = uop(A_WR_DOWN,  C_ALWAYS,      S_DEL);
            S_DEL_END:   w = uop(A_DEC_CNT,  C_ALWAYS,      S_EMIT);
            S_INS:       w = uop(A_SET_POS,  C_CNT_FULL,    S_FULL);
            S_SHIFT:     w = uop(A_NOP,      C_IDX_EQ_POS,  S_INS_WR);
            S_SHIFT_DEC: w = uop(A_DEC,      C_NEVER,       S_IDLE);
            S_SHIFT_RD:  w = uop(A_NOP,      C_NEVER,       S_IDLE);
            S_SHIFT_WR:  w = uop(A_WR_UP,    C_ALWAYS,      S_SHIFT);
            S_INS_WR:    w = uop(A_WR_NEW,   C_ALWAYS,      S_EMIT);
            S_FULL:      w = uop(A_SET_FULL, C_ALWAYS,      S_EMIT);
            S_EVAL:      w = uop(A_NOP,      C_IDX_EQ_CNT,  S_EMIT);
            S_EVAL_LD:   w = uop(A_POW_INIT, C_NEVER,       S_IDLE);
            S_POW:       w = uop(A_POW_STEP, C_E_GT1,       S_POW);
            S_TERM_MUL:  w = uop(A_TERM_MUL, C_NEVER,       S_IDLE);
            S_ACCUM:     w = uop(A_ACCUM,    C_ALWAYS,      S_EVAL);
            S_EMIT:      w = uop(A_EMIT,     C_ALWAYS,      S_IDLE);
            default:     w = uop(A_NOP,      C_ALWAYS,      S_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hdl/sparse_polynomial_term_store_eval.sv
// clear empties the table and the unused opcode changes nothing; add searches the terms in
// order, then merges into a match (deleting it when the sum is zero) or shifts later terms
// up and inserts; evaluate has the sequencer walk the term ram one entry at a time, with
// one power step per exponent bit (at least one) for each stored term
// one item at a time: busy is high from accept until the o_done beat, which the
// receiver cannot stall; synchronous active-low reset empties the table
`default_nettype none

module sparse_polynomial_term_store_eval #(
    parameter int MAX_TERMS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire [1:0]           i_opcode,
    input  wire signed [15:0]   i_term_coefficient,
    input  wire [5:0]           i_term_exponent,
    input  wire signed [15:0]   i_eval_point,
    output logic                o_done,
    output logic signed [31:0]  o_poly_value,
    output logic                o_table_full
);

    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int AW = $clog2(MAX_TERMS);
    localparam int TW = $bits(spte_pkg::t_term);

    spte_pkg::t_step  r_pc, n_pc;
    spte_pkg::t_uword uw;
    logic             jump;

    logic [CW-1:0] r_idx, n_idx, r_pos, n_pos, r_count, n_count;
    logic [CW-1:0] idx_p1, idx_m1;
    logic [1:0]    r_op, n_op;
    logic [31:0]   r_coef, n_coef, r_x, n_x, r_sum, n_sum, r_term, n_term;
    logic [31:0]   r_cf, n_cf, r_pa, n_pa, r_base, n_base;
    logic [5:0]    r_expo, n_expo, r_e, n_e;
    logic          r_full, n_full;
    logic          n_done;
    logic [31:0]   n_poly;

    logic [31:0]   mul_x, mul_y;
    logic [63:0]   mul_a, mul_b;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    spte_pkg::t_term  ram_wdata, ram_rdata;

    spte_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_TERMS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign uw     = spte_pkg::uc_rom(r_pc);
    assign busy   = (r_pc != spte_pkg::S_IDLE);
    assign idx_p1 = r_idx + CW'(1);
    assign idx_m1 = r_idx - CW'(1);

    assign mul_a = mul_x * mul_y;
    assign mul_b = r_base * r_base;

    always_comb begin
        case (uw.cond)
            spte_pkg::C_NEVER:       jump = 1'b0;
            spte_pkg::C_ALWAYS:      jump = 1'b1;
            spte_pkg::C_NOSTART:     jump = !start;
            spte_pkg::C_OP_ADD:      jump = (r_op == spte_pkg::OP_ADD);
            spte_pkg::C_OP_EVAL:     jump = (r_op == spte_pkg::OP_EVAL);
            spte_pkg::C_OP_NCLR:     jump = (r_op != spte_pkg::OP_CLEAR);
            spte_pkg::C_IDX_EQ_CNT:  jump = (r_idx == r_count);
            spte_pkg::C_EXP_EQ:      jump = (ram_rdata.expo == r_expo);
            spte_pkg::C_EXP_LT:      jump = (ram_rdata.expo < r_expo);
            spte_pkg::C_TERM_NZ:     jump = (r_term != 32'd0);
            spte_pkg::C_IDX1_GE_CNT: jump = (idx_p1 >= r_count);
            spte_pkg::C_CNT_FULL:    jump = (r_count == CW'(MAX_TERMS));
            spte_pkg::C_IDX_EQ_POS:  jump = (r_idx == r_pos);
            spte_pkg::C_E_GT1:       jump = (r_e > 6'd1);
            default:                 jump = 1'b0;
        endcase
        n_pc = jump ? uw.target : r_pc + spte_pkg::t_step'(1);
    end

    always_comb begin
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_count   = r_count;
        n_op      = r_op;
        n_coef    = r_coef;
        n_x       = r_x;
        n_sum     = r_sum;
        n_term    = r_term;
        n_cf      = r_cf;
        n_pa      = r_pa;
        n_base    = r_base;
        n_expo    = r_expo;
        n_e       = r_e;
        n_full    = r_full;
        n_done    = 1'b0;
        n_poly    = 32'd0;
        mul_x     = r_pa;
        mul_y     = r_base;
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = ram_rdata;
        case (uw.act)
            spte_pkg::A_LATCH: begin
                n_op   = i_opcode;
                n_coef = {{16{i_term_coefficient[15]}}, i_term_coefficient};
                n_expo = i_term_exponent;
                n_x    = {{16{i_eval_point[15]}}, i_eval_point};
                n_sum  = 32'd0;
                n_full = 1'b0;
                n_idx  = '0;
            end
            spte_pkg::A_CLEAR:   n_count = '0;
            spte_pkg::A_INC:     n_idx = idx_p1;
            spte_pkg::A_DEC:     n_idx = idx_m1;
            spte_pkg::A_MERGE:   n_term = ram_rdata.coef + r_coef;
            spte_pkg::A_WR_TERM: begin
                ram_we         = 1'b1;
                ram_wdata.coef = r_term;
                ram_wdata.expo = r_expo;
            end
            spte_pkg::A_WR_DOWN: begin
                ram_we    = 1'b1;
                ram_waddr = idx_m1[AW-1:0];
            end
            spte_pkg::A_WR_UP: begin
                ram_we    = 1'b1;
                ram_waddr = idx_p1[AW-1:0];
            end
            spte_pkg::A_WR_NEW: begin
                ram_we         = 1'b1;
                ram_wdata.coef = r_coef;
                ram_wdata.expo = r_expo;
                n_count        = r_count + CW'(1);
            end
            spte_pkg::A_DEC_CNT: n_count = r_count - CW'(1);
            spte_pkg::A_SET_POS: begin
                n_pos = r_idx;
                n_idx = r_count;
            end
            spte_pkg::A_SET_FULL: n_full = 1'b1;
            spte_pkg::A_POW_INIT: begin
                n_pa   = 32'd1;
                n_base = r_x;
                n_e    = ram_rdata.expo;
                n_cf   = ram_rdata.coef;
            end
            spte_pkg::A_POW_STEP: begin
                if (r_e[0]) begin
                    n_pa = mul_a[31:0];
                end
                n_base = mul_b[31:0];
                n_e    = r_e >> 1;
            end
            spte_pkg::A_TERM_MUL: begin
                mul_x  = r_cf;
                mul_y  = r_pa;
                n_term = mul_a[31:0];
            end
            spte_pkg::A_ACCUM: begin
                n_sum = r_sum + r_term;
                n_idx = idx_p1;
            end
            spte_pkg::A_EMIT: begin
                n_done = 1'b1;
                n_poly = r_sum;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= spte_pkg::S_IDLE;
            r_count      <= '0;
            o_done       <= 1'b0;
            o_poly_value <= '0;
            o_table_full <= 1'b0;
        end else begin
            r_pc         <= n_pc;
            r_count      <= n_count;
            o_done       <= n_done;
            o_poly_value <= n_poly;
            o_table_full <= n_done & r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_op   <= n_op;
        r_coef <= n_coef;
        r_x    <= n_x;
        r_sum  <= n_sum;
        r_term <= n_term;
        r_cf   <= n_cf;
        r_pa   <= n_pa;
        r_base <= n_base;
        r_expo <= n_expo;
        r_e    <= n_e;
        r_full <= n_full;
    end

endmodule

`default_nettype wire

>>> hdl/spte_ram.sv
// spte_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none

module spte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hdl/spte_checker.sv
// spte_checker: port-level checks of the sparse polynomial store, bound to the top level
// depends on sparse_polynomial_term_store_eval
`default_nettype none

module spte_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         start,
    input wire         busy,
    input wire         o_done,
    input wire [31:0]  o_poly_value,
    input wire         o_table_full
);

    // accepted beat makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted beat");

    // result beat comes as the sequencer returns to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two result beats in a row");

    a_full_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_table_full |-> o_poly_value == 32'd0)
        else $error("full flag with nonzero value");

    a_quiet_outputs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> (o_poly_value == 32'd0) && !o_table_full)
        else $error("result ports active without strobe");

endmodule

bind sparse_polynomial_term_store_eval spte_checker u_spte_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_poly_value (o_poly_value),
    .o_table_full (o_table_full)
);

`default_nettype wire

>>> sim/tb.sv
// tb: self-checking bench for sparse_polynomial_term_store_eval, driving clear, add,
// evaluate and unused beats against an in-bench term table model; uses spte_pkg
`timescale 1ns / 1ps

module tb;

    localparam int TERM_SLOTS = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        logic [31:0] poly_value;
        logic        table_full;
    } t_poly_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_opcode = 2'd0;
    logic signed [15:0] i_term_coefficient = 16'sd0;
    logic [5:0]         i_term_exponent = 6'd0;
    logic signed [15:0] i_eval_point = 16'sd0;
    logic               o_done;
    logic signed [31:0] o_poly_value;
    logic               o_table_full;

    logic [31:0] term_coef [TERM_SLOTS];
    logic [5:0]  term_expo [TERM_SLOTS];
    int          term_count = 0;

    t_poly_result pending_results[$];
    int           error_count = 0;
    bit           burst_mode = 1'b0;

    sparse_polynomial_term_store_eval #(
        .MAX_TERMS(TERM_SLOTS)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_opcode           (i_opcode),
        .i_term_coefficient (i_term_coefficient),
        .i_term_exponent    (i_term_exponent),
        .i_eval_point       (i_eval_point),
        .o_done             (o_done),
        .o_poly_value       (o_poly_value),
        .o_table_full       (o_table_full)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_500_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [31:0] wrap_power(logic [31:0] base, logic [5:0] e);
        logic [31:0] acc;
        logic [31:0] b;
        acc = 32'd1;
        b = base;
        for (int k = 0; k < 6; k++) begin
            if (e[k]) acc = acc * b;
            b = b * b;
        end
        return acc;
    endfunction

    function automatic logic merge_term(logic [31:0] c, logic [5:0] e);
        int pos;
        pos = 0;
        while (pos < term_count && term_expo[pos] > e) pos++;
        if (pos < term_count && term_expo[pos] == e) begin
            term_coef[pos] = term_coef[pos] + c;
            if (term_coef[pos] == 32'd0) begin
                for (int k = pos; k + 1 < term_count; k++) begin
                    term_coef[k] = term_coef[k + 1];
                    term_expo[k] = term_expo[k + 1];
                end
                term_count--;
            end
            return 1'b0;
        end
        if (term_count >= TERM_SLOTS) return 1'b1;
        for (int k = term_count; k > pos; k--) begin
            term_coef[k] = term_coef[k - 1];
            term_expo[k] = term_expo[k - 1];
        end
        term_coef[pos] = c;
        term_expo[pos] = e;
        term_count++;
        return 1'b0;
    endfunction

    function automatic logic [31:0] poly_at(logic [31:0] x);
        logic [31:0] sum;
        sum = 32'd0;
        for (int k = 0; k < term_count; k++)
            sum = sum + term_coef[k] * wrap_power(x, term_expo[k]);
        return sum;
    endfunction

    function automatic t_poly_result predict_poly(logic [1:0] op, logic signed [15:0] c,
                                                  logic [5:0] e, logic signed [15:0] x);
        t_poly_result r;
        r.poly_value = 32'd0;
        r.table_full = 1'b0;
        case (op)
            spte_pkg::OP_CLEAR: term_count = 0;
            spte_pkg::OP_ADD:   r.table_full = merge_term(32'(c), e);
            spte_pkg::OP_EVAL:  r.poly_value = poly_at(32'(x));
            default:  ;
        endcase
        return r;
    endfunction

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_poly_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report("result beat with nothing pending");
            end else begin
                want = pending_results.pop_front();
                if (o_poly_value !== want.poly_value)
                    report($sformatf("poly_value %08h, want %08h", o_poly_value,
                                     want.poly_value));
                if (o_table_full !== want.table_full)
                    report($sformatf("table_full %0b, want %0b", o_table_full,
                                     want.table_full));
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [15:0] c,
                             input logic [5:0] e, input logic [15:0] x);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start              <= 1'b1;
        i_opcode           <= op;
        i_term_coefficient <= c;
        i_term_exponent    <= e;
        i_eval_point       <= x;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.insert(pending_results.size(), predict_poly(op, c, e, x));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_table();
        send_item(spte_pkg::OP_EVAL, 16'($urandom), 6'($urandom), 16'sd0);
        send_item(OP_UNUSED, 16'($urandom), 6'($urandom), 16'($urandom));
        send_item(spte_pkg::OP_CLEAR, 16'($urandom), 6'($urandom), 16'($urandom));
    endtask

    task automatic test_special_terms();
        send_item(spte_pkg::OP_ADD, 16'sd0, 6'd5, 16'($urandom));
        send_item(spte_pkg::OP_ADD, 16'h8000, 6'd0, 16'($urandom));
        send_item(spte_pkg::OP_EVAL, 16'($urandom), 6'($urandom), 16'sd0);
        send_item(spte_pkg::OP_ADD, 16'sd32767, 6'd63, 16'($urandom));
        send_item(spte_pkg::OP_ADD, -16'sd32767, 6'd63, 16'($urandom));
        send_item(spte_pkg::OP_ADD, 16'sd0, 6'd5, 16'($urandom));
        send_item(spte_pkg::OP_EVAL, 16'($urandom), 6'($urandom), 16'h8000);
        send_item(spte_pkg::OP_EVAL, 16'($urandom), 6'($urandom), 16'sd32767);
    endtask

    task automatic test_full_table();
        logic [5:0] e;
        e = 6'd63;
        while (term_count < TERM_SLOTS) begin
            if (e != 6'd5 && e != 6'd0)
                send_item(spte_pkg::OP_ADD, 16'($urandom), e, 16'($urandom));
            e = e - 6'd4;
        end
        send_item(spte_pkg::OP_ADD, 16'sd1, 6'd2, 16'($urandom));
        send_item(spte_pkg::OP_EVAL, 16'($urandom), 6'($urandom), 16'sd3);
    endtask

    task automatic test_random_mix();
        int          pick;
        int          idx;
        int          held;
        logic [1:0]  op;
        logic [15:0] c;
        logic [5:0]  e;
        for (int seg = 0; seg < 30; seg++) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            if (seg == 7 || seg == 19) drain_results();
            for (int n = 0; n < 64; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 2) op = spte_pkg::OP_CLEAR;
                else if (pick < 5) op = OP_UNUSED;
                else if (pick < 55) op = spte_pkg::OP_ADD;
                else op = spte_pkg::OP_EVAL;
                c = 16'($urandom);
                e = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 20 && term_count > 0) begin
                    idx = $urandom_range(0, term_count - 1);
                    held = $signed(term_coef[idx]);
                    e = term_expo[idx];
                    if (held >= -32767 && held <= 32767) c = 16'(-held);
                end else if (pick < 28) begin
                    c = 16'd0;
                end else if (pick < 36) begin
                    c = ($urandom_range(0, 1) == 0) ? 16'h8000 : 16'h7fff;
                end
                send_item(op, c, e, 16'($urandom));
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_special_terms();
        test_full_table();
        test_random_mix();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
